// ===== hw/rtl/npps_pkg.sv =====
// npps_pkg: shared types and constants of the priority scheduler
// used by npps_cell and nonpreemptive_priority_scheduler; no dependencies
package npps_pkg;

  localparam int TIME_W = 16;   // arrival and burst width
  localparam int PRIO_W = 8;
  localparam int SLOT_W = 6;    // slot index, covers up to 64 cells
  localparam int CLK_W  = 22;   // schedule clock and per-job times
  localparam int SUM_W  = 27;   // running totals

  // candidate record handed from cell to cell along the chain
  typedef struct packed {
    logic              valid;     // a pickable job has been found
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] min_arr;   // earliest unserved arrival so far
  } cand_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic              load;
    logic [SLOT_W-1:0] load_slot;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
    logic              serve;
    logic [SLOT_W-1:0] serve_slot;
    logic              clear;
    logic [CLK_W-1:0]  clock_now;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/npps_cell.sv =====
// npps_cell: one job slot of the scheduler chain with its compare stage
// depends on npps_pkg (cand_t, cell_ctrl_t)
module npps_cell #(
  parameter logic [5:0] CELL_IDX = 6'd0
) (
  input  logic                clk,
  input  logic                rst,
  input  npps_pkg::cell_ctrl_t ctrl,
  input  npps_pkg::cand_t      cand_in,
  output npps_pkg::cand_t      cand_out
);
  import npps_pkg::*;

  logic              valid;
  logic              served;
  logic [TIME_W-1:0] arrival;
  logic [TIME_W-1:0] burst;
  logic [PRIO_W-1:0] prio;
  cand_t             cand_next;
  logic              open_job;
  logic              eligible;
  logic              better;

  // slot state: held job and its flags
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid  <= 1'b0;
      served <= 1'b0;
    end else begin
      if (ctrl.load && ctrl.load_slot == CELL_IDX) begin
        valid  <= 1'b1;
        served <= 1'b0;
      end
      if (ctrl.serve && ctrl.serve_slot == CELL_IDX) begin
        served <= 1'b1;
      end
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (ctrl.load && ctrl.load_slot == CELL_IDX) begin
      arrival <= ctrl.arrival;
      burst   <= ctrl.burst;
      prio    <= ctrl.prio;
    end
  end

  // compare own job against the incoming candidate
  always_comb begin
    open_job = valid && !served;
    eligible = open_job && ({{(CLK_W-TIME_W){1'b0}}, arrival} <= ctrl.clock_now);
    better   = !cand_in.valid || (prio < cand_in.prio) ||
               ((prio == cand_in.prio) && (arrival < cand_in.arrival));
    cand_next = cand_in;
    if (eligible && better) begin
      cand_next.valid   = 1'b1;
      cand_next.slot    = CELL_IDX;
      cand_next.arrival = arrival;
      cand_next.burst   = burst;
      cand_next.prio    = prio;
    end
    if (open_job && arrival < cand_in.min_arr) begin
      cand_next.min_arr = arrival;
    end
  end

  // hand the candidate to the next cell
  always_ff @(posedge clk) begin
    cand_out <= cand_next;
  end

endmodule

// ===== hw/rtl/nonpreemptive_priority_scheduler.sv =====
// nonpreemptive priority scheduler: jobs load one item per cycle; tlast starts the run.
// each pick is a pass down the chain of MAX_PROCS cells, with one extra pass whenever
// the clock must jump to the next arrival, plus one initial pass for the earliest
// arrival; each served job then steps through S_CALC, S_SUM and S_OUT, where S_OUT
// waits for the output to be free; s_axis_tready high only in load
// synchronous reset clears all slots, counters and the output valid
module nonpreemptive_priority_scheduler #(
  parameter int MAX_PROCS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // arrival[15:0], burst[31:16], prio_value[39:32]
  input  logic [39:0]  s_axis_tdata,
  input  logic         s_axis_tlast,    // final_job
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot[5:0], wait_ticks[27:6], turnaround[49:28], finish_time[71:50],
  // wait_total[98:72], turnaround_total[125:99], span[147:126], zero pad[151:148]
  output logic [151:0] m_axis_tdata,
  output logic         m_axis_tlast     // run_end
);
  import npps_pkg::*;

  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] NPROC = CNT_W'(MAX_PROCS);
  localparam logic [CLK_W-1:0] CLK_MAX = {CLK_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_PASS = 5'b00010,
    S_CALC = 5'b00100,
    S_SUM  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  function automatic logic [CLK_W-1:0] sat_clk(input logic [CLK_W:0] s);
    return s[CLK_W] ? CLK_MAX : s[CLK_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W:0] s);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  state_t            state;
  logic [CNT_W-1:0]  job_count;
  logic [CNT_W-1:0]  served_cnt;
  logic [CNT_W-1:0]  pass_cnt;
  logic              first_pass;
  logic [CLK_W-1:0]  clock_now;
  logic [TIME_W-1:0] first_arrival;
  logic [SUM_W-1:0]  wait_sum;
  logic [SUM_W-1:0]  turn_sum;
  logic [SLOT_W-1:0] pick_slot;
  logic [TIME_W-1:0] pick_arr;
  logic [TIME_W-1:0] pick_bur;
  logic [CLK_W-1:0]  wait_reg;
  logic [CLK_W-1:0]  turn_reg;
  logic [CLK_W-1:0]  finish_reg;

  cell_ctrl_t        ctrl;
  cand_t             chain [MAX_PROCS];
  cand_t             cand_init;
  cand_t             cand_end;

  logic              in_fire;
  logic              out_free;
  logic              pass_done;
  logic              last_job;
  logic [CLK_W-1:0]  wait_next;
  logic [CLK_W-1:0]  finish_next;
  logic [CLK_W-1:0]  turn_next;
  logic [SUM_W-1:0]  wait_sum_next;
  logic [SUM_W-1:0]  turn_sum_next;
  logic [CLK_W-1:0]  span_next;

  assign s_axis_tready = (state == S_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign cand_end      = chain[MAX_PROCS-1];
  assign pass_done     = (state == S_PASS) && (pass_cnt == NPROC);
  assign last_job      = (served_cnt + CNT_W'(1)) == job_count;

  // empty candidate fed into the head of the chain
  always_comb begin
    cand_init         = '0;
    cand_init.min_arr = {TIME_W{1'b1}};
  end

  // broadcast to the cells
  always_comb begin
    ctrl            = '0;
    ctrl.load       = in_fire && (job_count < NPROC);
    ctrl.load_slot  = SLOT_W'(job_count);
    ctrl.arrival    = s_axis_tdata[15:0];
    ctrl.burst      = s_axis_tdata[31:16];
    ctrl.prio       = s_axis_tdata[39:32];
    ctrl.serve      = (state == S_CALC);
    ctrl.serve_slot = pick_slot;
    ctrl.clear      = (state == S_OUT) && out_free && last_job;
    ctrl.clock_now  = clock_now;
  end

  // chain of job cells
  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    if (g == 0) begin : g_head
      npps_cell #(.CELL_IDX(6'(g))) u_cell (
        .clk(clk), .rst(rst), .ctrl(ctrl), .cand_in(cand_init), .cand_out(chain[g])
      );
    end else begin : g_body
      npps_cell #(.CELL_IDX(6'(g))) u_cell (
        .clk(clk), .rst(rst), .ctrl(ctrl), .cand_in(chain[g-1]), .cand_out(chain[g])
      );
    end
  end

  // per-job arithmetic, one add per step
  always_comb begin
    wait_next     = clock_now - {{(CLK_W-TIME_W){1'b0}}, pick_arr};
    finish_next   = sat_clk({1'b0, clock_now} + {{(CLK_W-TIME_W+1){1'b0}}, pick_bur});
    turn_next     = sat_clk({1'b0, wait_reg} + {{(CLK_W-TIME_W+1){1'b0}}, pick_bur});
    wait_sum_next = sat_sum({1'b0, wait_sum} + {{(SUM_W-CLK_W+1){1'b0}}, wait_reg});
    turn_sum_next = sat_sum({1'b0, turn_sum} + {{(SUM_W-CLK_W+1){1'b0}}, turn_reg});
    span_next     = finish_reg - {{(CLK_W-TIME_W){1'b0}}, first_arrival};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      job_count     <= '0;
      served_cnt    <= '0;
      pass_cnt      <= '0;
      first_pass    <= 1'b0;
      clock_now     <= '0;
      first_arrival <= '0;
      wait_sum      <= '0;
      turn_sum      <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (job_count < NPROC) begin
              job_count <= job_count + CNT_W'(1);
            end
            if (s_axis_tlast) begin
              state      <= S_PASS;
              first_pass <= 1'b1;
              pass_cnt   <= '0;
              served_cnt <= '0;
              wait_sum   <= '0;
              turn_sum   <= '0;
            end
          end
        end
        S_PASS: begin
          if (!pass_done) begin
            pass_cnt <= pass_cnt + CNT_W'(1);
          end else if (first_pass) begin
            // schedule starts at the earliest arrival
            clock_now     <= {{(CLK_W-TIME_W){1'b0}}, cand_end.min_arr};
            first_arrival <= cand_end.min_arr;
            first_pass    <= 1'b0;
            pass_cnt      <= '0;
          end else if (!cand_end.valid) begin
            // idle gap: jump to the next arrival and scan again
            clock_now <= {{(CLK_W-TIME_W){1'b0}}, cand_end.min_arr};
            pass_cnt  <= '0;
          end else begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          clock_now <= finish_next;
          state     <= S_SUM;
        end
        S_SUM: begin
          wait_sum <= wait_sum_next;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            turn_sum      <= turn_sum_next;
            served_cnt    <= served_cnt + CNT_W'(1);
            pass_cnt      <= '0;
            if (last_job) begin
              job_count <= '0;
              state     <= S_LOAD;
            end else begin
              state <= S_PASS;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // output valid: set on a new result, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // picked job and per-job times
  always_ff @(posedge clk) begin
    if (pass_done) begin
      pick_slot <= cand_end.slot;
      pick_arr  <= cand_end.arrival;
      pick_bur  <= cand_end.burst;
    end
    if (state == S_CALC) begin
      wait_reg   <= wait_next;
      finish_reg <= finish_next;
    end
    if (state == S_SUM) begin
      turn_reg <= turn_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_axis_tlast <= last_job;
      if (last_job) begin
        m_axis_tdata <= {4'b0, span_next, turn_sum_next, wait_sum,
                         finish_reg, turn_reg, wait_reg, pick_slot};
      end else begin
        m_axis_tdata <= {4'b0, {CLK_W{1'b0}}, {SUM_W{1'b0}}, {SUM_W{1'b0}},
                         finish_reg, turn_reg, wait_reg, pick_slot};
      end
    end
  end

endmodule
